// File: rtl/core/tick_divider_table_macros.svh
// tick_divider_table_macros.svh: assertion macros for the tick divider table
// used by the top level; no other dependencies
`ifndef TICK_DIVIDER_TABLE_MACROS_SVH
`define TICK_DIVIDER_TABLE_MACROS_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define TDT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked at every rising clock edge outside reset
`define TDT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/tdt_pkg.sv
// tdt_pkg: shared sizes, codes and controller/datapath interface structs
// for the tick divider table; no dependencies
`default_nettype none

package tdt_pkg;

   // table geometry
   localparam int SLOTS      = 8;
   localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W      = $clog2(SLOTS + 1);

   // field widths
   localparam int CMD_W    = 2;
   localparam int ID_W     = 8;
   localparam int DIV_W    = 32;
   localparam int STATUS_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK   = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_REMOVE = 2'd2
   } cmd_code_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_ZERO_DIV  = 2'd3
   } status_code_type;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_FIRE   = 1'b1;

   // commands from controller to datapath
   typedef struct packed {
      logic            capture;
      logic            clr_idx;
      logic            step_idx;
      logic            tick_visit;
      logic            tick_flush;
      logic            do_add;
      logic            do_shift;
      logic            emit_status;
      status_code_type status_code;
   } dp_ctrl_type;

   // status from datapath to controller
   typedef struct packed {
      logic idx_done;
      logic id_match;
      logic table_full;
      logic zero_div;
      logic pend_valid;
   } dp_stat_type;

endpackage

`default_nettype wire

// File: rtl/core/tick_divider_table.sv
// tick_divider_table: an add result follows from the add state, a remove result from the
// shift state after a search up to the matching slot (or a not-found after all used slots).
// tick walks one occupied slot a cycle and stays busy until the walk is done; each fire
// waits for the next firing slot's visit, the final one is sent once the walk is done.
// one request at a time; the walk over the slot table's single read port sets the rate.
// synchronous reset empties the table and drops any pending result; results cannot stall.
`default_nettype none

`include "tick_divider_table_macros.svh"

module tick_divider_table (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [tdt_pkg::CMD_W-1:0]    req_cmd,
   input  wire logic [tdt_pkg::ID_W-1:0]     req_handler_id,
   input  wire logic [tdt_pkg::DIV_W-1:0]    req_divisor,
   output logic                              rsp_valid,
   output logic                              rsp_kind,
   output logic [tdt_pkg::STATUS_W-1:0]      rsp_status,
   output logic [tdt_pkg::ID_W-1:0]          rsp_fired_id,
   output logic                              rsp_last
);
   import tdt_pkg::*;

   dp_ctrl_type ctrl;
   dp_stat_type stat;

   logic cmd_request;
   logic status_out;
   logic fire_out;
   logic final_out;

   // sequencer
   tdt_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .busy    (busy),
      .ctrl    (ctrl),
      .stat    (stat)
   );

   // slot table and result path
   tdt_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .stat           (stat),
      .req_handler_id (req_handler_id),
      .req_divisor    (req_divisor),
      .rsp_valid      (rsp_valid),
      .rsp_kind       (rsp_kind),
      .rsp_status     (rsp_status),
      .rsp_fired_id   (rsp_fired_id),
      .rsp_last       (rsp_last)
   );

   // handshake terms for the checks below
   assign cmd_request = start && !busy && (req_cmd == CMD_ADD || req_cmd == CMD_REMOVE);
   assign status_out  = rsp_valid && (rsp_kind == KIND_STATUS);
   assign fire_out    = rsp_valid && (rsp_kind == KIND_FIRE);
   assign final_out   = rsp_valid && rsp_last;

   // add and remove requests keep the block busy until their status result
   `TDT_ASSERT_NEXT(a_cmd_busy, cmd_request, busy, "add or remove request did not raise busy")

   // the final result of a request only shows once the block is free again
   `TDT_ASSERT_NOW(a_last_idle, final_out, !busy, "final result while still busy")

   // a status result is always the only one of its request
   `TDT_ASSERT_NOW(a_status_last, status_out, rsp_last, "status result without last")

   // fire results carry a clean status
   `TDT_ASSERT_NOW(a_fire_ok, fire_out, rsp_status == STAT_OK, "fire result with nonzero status")

endmodule

`default_nettype wire

// File: rtl/core/tdt_datapath.sv
// tdt_datapath: slot table, walk index, pending fire buffer and result registers
// depends on tdt_pkg
`default_nettype none

module tdt_datapath (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire tdt_pkg::dp_ctrl_type     ctrl,
   output tdt_pkg::dp_stat_type          stat,
   input  wire logic [tdt_pkg::ID_W-1:0] req_handler_id,
   input  wire logic [tdt_pkg::DIV_W-1:0] req_divisor,
   output logic                          rsp_valid,
   output logic                          rsp_kind,
   output logic [tdt_pkg::STATUS_W-1:0]  rsp_status,
   output logic [tdt_pkg::ID_W-1:0]      rsp_fired_id,
   output logic                          rsp_last
);
   import tdt_pkg::*;

   // slot table
   logic [ID_W-1:0]  slot_ids_ff       [SLOTS];
   logic [DIV_W-1:0] slot_reload_ff    [SLOTS];
   logic [DIV_W-1:0] slot_remaining_ff [SLOTS];

   logic [CNT_W-1:0] used_ff, used_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [ID_W-1:0]  id_ff;
   logic [DIV_W-1:0] div_ff;
   logic             pend_valid_ff, pend_valid_in;
   logic [ID_W-1:0]  pend_id_ff, pend_id_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_kind_ff, rsp_kind_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]     rsp_fired_id_ff, rsp_fired_id_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [SLOT_IDX_W-1:0] rd_addr;
   logic [SLOT_IDX_W-1:0] wr_addr;
   logic [ID_W-1:0]       id_rd;
   logic [DIV_W-1:0]      reload_rd;
   logic [DIV_W-1:0]      remaining_rd;
   logic                  hit;

   // current slot under the walk index
   assign rd_addr      = idx_ff[SLOT_IDX_W-1:0];
   assign wr_addr      = used_ff[SLOT_IDX_W-1:0];
   assign id_rd        = slot_ids_ff[rd_addr];
   assign reload_rd    = slot_reload_ff[rd_addr];
   assign remaining_rd = slot_remaining_ff[rd_addr];
   assign hit          = (remaining_rd == DIV_W'(1));

   // status back to the controller
   assign stat.idx_done   = (idx_ff == used_ff);
   assign stat.id_match   = (id_rd == id_ff);
   assign stat.table_full = (used_ff == CNT_W'(SLOTS));
   assign stat.zero_div   = (div_ff == '0);
   assign stat.pend_valid = pend_valid_ff;

   // walk index and occupancy
   always_comb begin
      idx_in = idx_ff;
      if (ctrl.clr_idx) begin
         idx_in = '0;
      end else if (ctrl.step_idx) begin
         idx_in = idx_ff + CNT_W'(1);
      end
      used_in = used_ff;
      if (ctrl.do_add) begin
         used_in = used_ff + CNT_W'(1);
      end else if (ctrl.do_shift) begin
         used_in = used_ff - CNT_W'(1);
      end
   end

   // one fire held back so the final one of a tick can carry last
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      if (ctrl.capture || ctrl.tick_flush) begin
         pend_valid_in = 1'b0;
      end else if (ctrl.tick_visit && hit) begin
         pend_valid_in = 1'b1;
         pend_id_in    = id_rd;
      end
   end

   // result selection
   always_comb begin
      rsp_valid_in    = 1'b0;
      rsp_kind_in     = KIND_STATUS;
      rsp_status_in   = STAT_OK;
      rsp_fired_id_in = '0;
      rsp_last_in     = 1'b0;
      if (ctrl.emit_status) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ctrl.status_code;
         rsp_last_in   = 1'b1;
      end else if (ctrl.tick_visit && hit && pend_valid_ff) begin
         rsp_valid_in    = 1'b1;
         rsp_kind_in     = KIND_FIRE;
         rsp_fired_id_in = pend_id_ff;
      end else if (ctrl.tick_flush) begin
         rsp_valid_in    = 1'b1;
         rsp_kind_in     = KIND_FIRE;
         rsp_fired_id_in = pend_id_ff;
         rsp_last_in     = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         used_ff       <= used_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff          <= idx_in;
      pend_id_ff      <= pend_id_in;
      rsp_kind_ff     <= rsp_kind_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_fired_id_ff <= rsp_fired_id_in;
      rsp_last_ff     <= rsp_last_in;
      if (ctrl.capture) begin
         id_ff  <= req_handler_id;
         div_ff <= req_divisor;
      end
   end

   // slot table updates: append, per-slot tick, compaction after remove
   always_ff @(posedge clock) begin
      if (ctrl.do_add) begin
         slot_ids_ff[wr_addr]       <= id_ff;
         slot_reload_ff[wr_addr]    <= div_ff;
         slot_remaining_ff[wr_addr] <= div_ff;
      end
      if (ctrl.tick_visit) begin
         slot_remaining_ff[rd_addr] <= hit ? reload_rd : (remaining_rd - DIV_W'(1));
      end
      if (ctrl.do_shift) begin
         for (int j = 0; j < SLOTS - 1; j++) begin
            if ((CNT_W'(j) >= idx_ff) && (CNT_W'(j + 1) < used_ff)) begin
               slot_ids_ff[j]       <= slot_ids_ff[j + 1];
               slot_reload_ff[j]    <= slot_reload_ff[j + 1];
               slot_remaining_ff[j] <= slot_remaining_ff[j + 1];
            end
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_fired_id = rsp_fired_id_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

`default_nettype wire

// File: rtl/core/tdt_ctrl.sv
// tdt_ctrl: request sequencer for the tick divider table
// depends on tdt_pkg
`default_nettype none

module tdt_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [tdt_pkg::CMD_W-1:0] req_cmd,
   output logic                           busy,
   output tdt_pkg::dp_ctrl_type           ctrl,
   input  wire tdt_pkg::dp_stat_type      stat
);
   import tdt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_SEARCH,
      ST_SHIFT,
      ST_TICK
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      accept;

   assign accept = start && !busy_ff;

   // next state and datapath commands
   always_comb begin
      state_in         = state_ff;
      ctrl             = '0;
      ctrl.status_code = STAT_OK;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctrl.capture = 1'b1;
               ctrl.clr_idx = 1'b1;
               case (req_cmd)
                  CMD_TICK:   state_in = ST_TICK;
                  CMD_ADD:    state_in = ST_ADD;
                  CMD_REMOVE: state_in = ST_SEARCH;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD: begin
            ctrl.emit_status = 1'b1;
            if (stat.table_full) begin
               ctrl.status_code = STAT_FULL;
            end else if (stat.zero_div) begin
               ctrl.status_code = STAT_ZERO_DIV;
            end else begin
               ctrl.do_add = 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_SEARCH: begin
            if (stat.idx_done) begin
               ctrl.emit_status = 1'b1;
               ctrl.status_code = STAT_NOT_FOUND;
               state_in         = ST_IDLE;
            end else if (stat.id_match) begin
               state_in = ST_SHIFT;
            end else begin
               ctrl.step_idx = 1'b1;
            end
         end
         ST_SHIFT: begin
            ctrl.do_shift    = 1'b1;
            ctrl.emit_status = 1'b1;
            state_in         = ST_IDLE;
         end
         ST_TICK: begin
            if (stat.idx_done) begin
               ctrl.tick_flush = stat.pend_valid;
               state_in        = ST_IDLE;
            end else begin
               ctrl.tick_visit = 1'b1;
               ctrl.step_idx   = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      busy_in = (state_in != ST_IDLE);
   end

   // state and registered busy
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

// File: verif/tick_divider_table_tb.sv
// tick_divider_table_tb: self-checking bench for the tick divider table, directed
// table of requests followed by random add/remove/tick traffic; needs tdt_pkg and the rtl

module tick_divider_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tdt_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_REQUESTS = 480;
   localparam int STALL_LIMIT     = 400;
   localparam int DRAIN_CYCLES    = 2 * SLOTS + 8;

   // one result the table is expected to produce
   typedef struct packed {
      logic            kind;
      status_code_type status;
      logic [ID_W-1:0] fired_id;
      logic            last;
   } table_event_type;

   // one row of the directed request plan
   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [ID_W-1:0]  id;
      logic [DIV_W-1:0] div;
      logic             typed;
      status_code_type  status;
   } plan_row_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [CMD_W-1:0]    req_cmd;
   logic [ID_W-1:0]     req_handler_id;
   logic [DIV_W-1:0]    req_divisor;
   logic                rsp_valid;
   logic                rsp_kind;
   logic [STATUS_W-1:0] rsp_status;
   logic [ID_W-1:0]     rsp_fired_id;
   logic                rsp_last;

   tick_divider_table dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_handler_id (req_handler_id),
      .req_divisor    (req_divisor),
      .rsp_valid      (rsp_valid),
      .rsp_kind       (rsp_kind),
      .rsp_status     (rsp_status),
      .rsp_fired_id   (rsp_fired_id),
      .rsp_last       (rsp_last)
   );

   // shadow copy of the divider table
   logic [ID_W-1:0]  shadow_id     [SLOTS];
   logic [DIV_W-1:0] shadow_reload [SLOTS];
   logic [DIV_W-1:0] shadow_left   [SLOTS];
   int               shadow_count;

   table_event_type request_events [$];
   table_event_type awaited_events [$];

   int error_count   = 0;
   int requests_sent;
   int fires_seen    = 0;
   int statuses_seen = 0;
   int full_seen     = 0;
   int stall_cycles  = 0;

   // directed plan: empty table, zero divisor, extremes, duplicates, full table,
   // unused command, first-match remove, multi-fire ticks
   plan_row_type directed_plan [24] = '{
      '{CMD_TICK,   8'h00, 32'h0000_0000, 1'b0, STAT_OK},
      '{CMD_REMOVE, 8'h00, 32'h0000_0000, 1'b1, STAT_NOT_FOUND},
      '{CMD_ADD,    8'h00, 32'h0000_0000, 1'b1, STAT_ZERO_DIV},
      '{CMD_ADD,    8'hFF, 32'h0000_0001, 1'b1, STAT_OK},
      '{CMD_ADD,    8'h00, 32'hFFFF_FFFF, 1'b1, STAT_OK},
      '{CMD_ADD,    8'h5A, 32'h0000_0002, 1'b1, STAT_OK},
      '{CMD_ADD,    8'h5A, 32'h0000_0003, 1'b1, STAT_OK},
      '{CMD_TICK,   8'hFF, 32'hFFFF_FFFF, 1'b0, STAT_OK},
      '{CMD_TICK,   8'h00, 32'h0000_0000, 1'b0, STAT_OK},
      '{CMD_UNUSED, 8'hAA, 32'h0000_0007, 1'b0, STAT_OK},
      '{CMD_ADD,    8'hA5, 32'h0000_0001, 1'b1, STAT_OK},
      '{CMD_ADD,    8'h01, 32'h0000_0001, 1'b1, STAT_OK},
      '{CMD_ADD,    8'h02, 32'h0000_0001, 1'b1, STAT_OK},
      '{CMD_ADD,    8'h03, 32'h0000_0004, 1'b1, STAT_OK},
      '{CMD_ADD,    8'h04, 32'h0000_0005, 1'b1, STAT_FULL},
      '{CMD_ADD,    8'h04, 32'h0000_0000, 1'b1, STAT_FULL},
      '{CMD_TICK,   8'h55, 32'h5555_5555, 1'b0, STAT_OK},
      '{CMD_REMOVE, 8'h5A, 32'h0000_0000, 1'b1, STAT_OK},
      '{CMD_REMOVE, 8'h77, 32'h0000_0000, 1'b1, STAT_NOT_FOUND},
      '{CMD_TICK,   8'h00, 32'h0000_0000, 1'b0, STAT_OK},
      '{CMD_REMOVE, 8'hFF, 32'hFFFF_FFFF, 1'b1, STAT_OK},
      '{CMD_REMOVE, 8'h03, 32'h0000_0000, 1'b1, STAT_OK},
      '{CMD_TICK,   8'h00, 32'h0000_0000, 1'b0, STAT_OK},
      '{CMD_TICK,   8'h00, 32'h0000_0000, 1'b0, STAT_OK}
   };

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // advance the shadow table by one request, results go to request_events
   function automatic void advance_divider_table(input logic [CMD_W-1:0] cmd,
                                                 input logic [ID_W-1:0] id,
                                                 input logic [DIV_W-1:0] div);
      table_event_type ev;
      int              hit;
      request_events.delete();
      case (cmd)
         CMD_TICK: begin
            for (int i = 0; i < shadow_count; i++) begin
               if (shadow_left[i] == 32'd1) begin
                  shadow_left[i] = shadow_reload[i];
                  ev.kind     = KIND_FIRE;
                  ev.status   = STAT_OK;
                  ev.fired_id = shadow_id[i];
                  ev.last     = 1'b0;
                  request_events.push_back(ev);
               end else begin
                  shadow_left[i] = shadow_left[i] - 32'd1;
               end
            end
            if (request_events.size() > 0)
               request_events[request_events.size() - 1].last = 1'b1;
         end
         CMD_ADD: begin
            ev = '{KIND_STATUS, STAT_OK, '0, 1'b1};
            if (shadow_count >= SLOTS) begin
               ev.status = STAT_FULL;
            end else if (div == '0) begin
               ev.status = STAT_ZERO_DIV;
            end else begin
               shadow_id[shadow_count]     = id;
               shadow_reload[shadow_count] = div;
               shadow_left[shadow_count]   = div;
               shadow_count++;
            end
            request_events.push_back(ev);
         end
         CMD_REMOVE: begin
            ev  = '{KIND_STATUS, STAT_NOT_FOUND, '0, 1'b1};
            hit = -1;
            for (int i = 0; i < shadow_count; i++) begin
               if (hit < 0 && shadow_id[i] == id)
                  hit = i;
            end
            if (hit >= 0) begin
               for (int i = hit; i + 1 < shadow_count; i++) begin
                  shadow_id[i]     = shadow_id[i + 1];
                  shadow_reload[i] = shadow_reload[i + 1];
                  shadow_left[i]   = shadow_left[i + 1];
               end
               shadow_count--;
               ev.status = STAT_OK;
            end
            request_events.push_back(ev);
         end
         default: ;
      endcase
   endfunction

   // send one request after a gap, predict once it is accepted
   task automatic issue_request(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                                input logic [DIV_W-1:0] div, input int gap,
                                input logic typed, input status_code_type typed_status);
      table_event_type typed_ev;
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start          <= 1'b1;
      req_cmd        <= cmd;
      req_handler_id <= id;
      req_divisor    <= div;
      do @(posedge clock); while (busy);
      requests_sent++;
      advance_divider_table(cmd, id, div);
      if (typed) begin
         typed_ev = '{KIND_STATUS, typed_status, '0, 1'b1};
         awaited_events.push_back(typed_ev);
      end else begin
         foreach (request_events[i]) awaited_events.push_back(request_events[i]);
      end
   endtask

   // hold the sender off until every owed result has come back
   task automatic wait_for_results();
      @(negedge clock);
      start <= 1'b0;
      while (awaited_events.size() > 0) @(posedge clock);
   endtask

   // result checker
   always @(posedge clock) begin
      table_event_type want;
      if (!reset && rsp_valid) begin
         if (awaited_events.size() == 0) begin
            $error("unexpected result: kind %0d status %0d fired_id %0h last %0d",
                   rsp_kind, rsp_status, rsp_fired_id, rsp_last);
            error_count++;
         end else begin
            want = awaited_events.pop_front();
            if (rsp_kind !== want.kind) begin
               $error("rsp_kind expected %0d got %0d", want.kind, rsp_kind);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $error("rsp_status expected %0d got %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_fired_id !== want.fired_id) begin
               $error("rsp_fired_id expected %0h got %0h", want.fired_id, rsp_fired_id);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $error("rsp_last expected %0d got %0d", want.last, rsp_last);
               error_count++;
            end
            if (want.kind == KIND_FIRE)
               fires_seen++;
            else
               statuses_seen++;
            if (want.kind == KIND_STATUS && want.status == STAT_FULL)
               full_seen++;
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // stimulus
   initial begin
      logic [CMD_W-1:0] cmd;
      logic [ID_W-1:0]  id;
      logic [DIV_W-1:0] div;
      int               pick;
      int               gap;
      bit               filling;
      bit               bursting;

      reset          = 1'b1;
      start          = 1'b0;
      req_cmd        = CMD_TICK;
      req_handler_id = '0;
      req_divisor    = '0;
      requests_sent  = 0;
      shadow_count   = 0;
      filling        = 1'b1;
      bursting       = 1'b0;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed plan
      foreach (directed_plan[i]) begin
         gap = $urandom_range(0, 10);
         issue_request(directed_plan[i].cmd, directed_plan[i].id, directed_plan[i].div,
                       gap, directed_plan[i].typed, directed_plan[i].status);
      end
      wait_for_results();

      // random traffic, alternating fill and drain phases
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 40 == 0) begin
            filling  = ~filling;
            bursting = ($urandom_range(0, 3) == 0);
         end
         if (n % 120 == 119)
            wait_for_results();

         pick = $urandom_range(0, 99);
         id   = ID_W'($urandom);
         div  = $urandom;
         if (pick < 45)
            cmd = CMD_TICK;
         else if (pick < (filling ? 85 : 55))
            cmd = CMD_ADD;
         else if (pick < 97)
            cmd = CMD_REMOVE;
         else
            cmd = CMD_UNUSED;

         // small divisors so entries fire often, with a few zero and extreme ones
         if (cmd == CMD_ADD) begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
               div = '0;
            else if (pick < 8)
               div = '1;
            else if (pick >= 16)
               div = $urandom_range(1, 6);
            if ($urandom_range(0, 1) == 0)
               id = ID_W'($urandom_range(0, 7));
         end

         // mostly remove ids that are in the table
         if (cmd == CMD_REMOVE && shadow_count > 0 && $urandom_range(0, 3) != 0)
            id = shadow_id[$urandom_range(0, shadow_count - 1)];

         gap = bursting ? 0 : $urandom_range(0, 10);
         issue_request(cmd, id, div, gap, 1'b0, STAT_OK);
      end

      // drain
      @(negedge clock);
      start <= 1'b0;
      while (awaited_events.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d requests: %0d status results (%0d table full), %0d fire results",
               requests_sent, statuses_seen, full_seen, fires_seen);
      $display("mismatches: %0d", error_count);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
